// ----- rtl/esr_pkg.sv -----
`default_nettype none

package esr_pkg;

  // Signed coordinate width; covers every placement for displays up to 64 x 64.
  localparam int COORD_W    = 9;
  localparam int LEVEL_W    = 8;
  localparam int NUM_LEVELS = 4;
  localparam int ADDR_W     = 2;
  localparam int SHADE_N    = 20;

  // Register indexes on the configuration port.
  localparam logic [ADDR_W-1:0] REG_LEVEL_FULL   = 2'd0;
  localparam logic [ADDR_W-1:0] REG_LEVEL_DIM    = 2'd1;
  localparam logic [ADDR_W-1:0] REG_LEVEL_MID    = 2'd2;
  localparam logic [ADDR_W-1:0] REG_LEVEL_BRIGHT = 2'd3;

  // Register reset values.
  localparam logic [LEVEL_W-1:0] LEVEL_FULL_RST   = 8'd30;
  localparam logic [LEVEL_W-1:0] LEVEL_DIM_RST    = 8'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MID_RST    = 8'd9;
  localparam logic [LEVEL_W-1:0] LEVEL_BRIGHT_RST = 8'd22;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef level_t [NUM_LEVELS-1:0] level_bank_t;

  // One input item as it sits in the input register.
  typedef struct packed {
    logic [4:0]        eye_cols;
    logic [3:0]        eye_rows;
    logic signed [4:0] eye_offset_x;
    logic signed [4:0] eye_offset_y;
    logic [4:0]        iris_width;
    logic [3:0]        iris_height;
    logic signed [4:0] iris_offset_x;
    logic signed [4:0] iris_offset_y;
    logic [3:0]        pixel_x;
    logic [3:0]        pixel_y;
  } item_t;

  // Placed rectangles plus the size flags that gate blanking and shading.
  typedef struct packed {
    coord_t     top;
    coord_t     bottom;
    coord_t     left;
    coord_t     right;
    coord_t     itop;
    coord_t     ibot;
    coord_t     ileft;
    coord_t     iright;
    logic [3:0] pixel_x;
    logic [3:0] pixel_y;
    logic       on_display;
    logic       w_gt1;
    logic       w_gt2;
    logic       h_gt1;
    logic       h_gt2;
    logic       shade_on;
  } geom_t;

  // One shading pixel: position relative to an eye edge and its level register.
  typedef struct packed {
    logic              from_right;
    logic [1:0]        xoff;
    logic              from_bottom;
    logic [1:0]        yoff;
    logic [ADDR_W-1:0] lvl;
  } shade_entry_t;

  // Shading pixels in drawing order; a later entry overrides an earlier one.
  localparam shade_entry_t SHADE_TAB [0:SHADE_N-1] = '{
    '{1'b1, 2'd2, 1'b0, 2'd0, REG_LEVEL_DIM},
    '{1'b0, 2'd1, 1'b0, 2'd0, REG_LEVEL_DIM},
    '{1'b1, 2'd1, 1'b0, 2'd1, REG_LEVEL_DIM},
    '{1'b0, 2'd0, 1'b0, 2'd1, REG_LEVEL_DIM},
    '{1'b1, 2'd2, 1'b1, 2'd1, REG_LEVEL_DIM},
    '{1'b0, 2'd1, 1'b1, 2'd1, REG_LEVEL_DIM},
    '{1'b1, 2'd1, 1'b1, 2'd2, REG_LEVEL_DIM},
    '{1'b0, 2'd0, 1'b1, 2'd2, REG_LEVEL_DIM},
    '{1'b1, 2'd3, 1'b0, 2'd0, REG_LEVEL_MID},
    '{1'b0, 2'd2, 1'b0, 2'd0, REG_LEVEL_MID},
    '{1'b1, 2'd1, 1'b0, 2'd2, REG_LEVEL_MID},
    '{1'b0, 2'd0, 1'b0, 2'd2, REG_LEVEL_MID},
    '{1'b1, 2'd3, 1'b1, 2'd1, REG_LEVEL_MID},
    '{1'b0, 2'd2, 1'b1, 2'd1, REG_LEVEL_MID},
    '{1'b1, 2'd1, 1'b1, 2'd3, REG_LEVEL_MID},
    '{1'b0, 2'd0, 1'b1, 2'd3, REG_LEVEL_MID},
    '{1'b1, 2'd2, 1'b0, 2'd1, REG_LEVEL_BRIGHT},
    '{1'b0, 2'd1, 1'b0, 2'd1, REG_LEVEL_BRIGHT},
    '{1'b1, 2'd2, 1'b1, 2'd2, REG_LEVEL_BRIGHT},
    '{1'b0, 2'd1, 1'b1, 2'd2, REG_LEVEL_BRIGHT}
  };

  // Halves a doubled coordinate, rounding half away from zero.
  // A negative value rounds correctly with a plain arithmetic shift.
  function automatic coord_t round_half(coord_t v);
    coord_t t;
    t = v + (v[COORD_W-1] ? coord_t'(0) : coord_t'(1));
    return t >>> 1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/esr_geom.sv -----
`default_nettype none

module esr_geom
  import esr_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = 16,
  parameter int DISPLAY_HEIGHT = 9
) (
  input  item_t item,
  output geom_t geom
);

  coord_t ew, eh, iw, ih;
  coord_t ox, oy, iox, ioy;
  coord_t top, left, itop0, ileft0, itop1, ileft1;
  coord_t bottom, right, itop, ileft;

  // Widen every field to a signed coordinate.
  assign ew  = coord_t'(item.eye_cols);
  assign eh  = coord_t'(item.eye_rows);
  assign iw  = coord_t'(item.iris_width);
  assign ih  = coord_t'(item.iris_height);
  assign ox  = coord_t'(item.eye_offset_x);
  assign oy  = coord_t'(item.eye_offset_y);
  assign iox = coord_t'(item.iris_offset_x);
  assign ioy = coord_t'(item.iris_offset_y);

  // Eye rectangle centered on the display, computed in half pixels.
  assign top    = round_half(coord_t'(DISPLAY_HEIGHT) - eh + (oy <<< 1));
  assign left   = round_half(coord_t'(DISPLAY_WIDTH) - ew + (ox <<< 1));
  assign bottom = top + eh;
  assign right  = left + ew;

  // Iris placement, then clamped inside the eye: lower bound first.
  assign itop0  = round_half(coord_t'(DISPLAY_HEIGHT) - ih + ((oy + ioy) <<< 1));
  assign ileft0 = round_half(coord_t'(DISPLAY_WIDTH) - iw + ((ox + iox) <<< 1));
  assign itop1  = (itop0 > top) ? itop0 : top;
  assign ileft1 = (ileft0 > left) ? ileft0 : left;
  assign itop   = (itop1 > bottom - ih) ? bottom - ih : itop1;
  assign ileft  = (ileft1 > right - iw) ? right - iw : ileft1;

  always_comb begin
    geom            = '0;
    geom.top        = top;
    geom.bottom     = bottom;
    geom.left       = left;
    geom.right      = right;
    geom.itop       = itop;
    geom.ileft      = ileft;
    geom.ibot       = (itop + ih > bottom) ? bottom : itop + ih;
    geom.iright     = (ileft + iw > right) ? right : ileft + iw;
    geom.pixel_x    = item.pixel_x;
    geom.pixel_y    = item.pixel_y;
    geom.on_display = (int'(item.pixel_x) < DISPLAY_WIDTH) &&
                      (int'(item.pixel_y) < DISPLAY_HEIGHT);
    geom.w_gt1      = item.eye_cols > 5'd1;
    geom.w_gt2      = item.eye_cols > 5'd2;
    geom.h_gt1      = item.eye_rows > 4'd1;
    geom.h_gt2      = item.eye_rows > 4'd2;
    geom.shade_on   = (item.eye_cols > 5'd4) && (item.eye_rows > 4'd4);
  end

endmodule

`default_nettype wire

// ----- rtl/esr_shade.sv -----
`default_nettype none

module esr_shade
  import esr_pkg::*;
(
  input  geom_t       geom,
  input  level_bank_t levels,
  output level_t      level
);

  coord_t            px, py;
  logic [ADDR_W-1:0] shade_sel;
  logic              shade_hit;

  assign px = coord_t'(geom.pixel_x);
  assign py = coord_t'(geom.pixel_y);

  // Last matching shading pixel wins, as it is drawn last.
  always_comb begin
    coord_t sx, sy;
    shade_sel = REG_LEVEL_DIM;
    shade_hit = 1'b0;
    sx        = '0;
    sy        = '0;
    for (int i = 0; i < SHADE_N; i++) begin
      sx = SHADE_TAB[i].from_right ? geom.right - coord_t'(SHADE_TAB[i].xoff)
                                   : geom.left + coord_t'(SHADE_TAB[i].xoff);
      sy = SHADE_TAB[i].from_bottom ? geom.bottom - coord_t'(SHADE_TAB[i].yoff)
                                    : geom.top + coord_t'(SHADE_TAB[i].yoff);
      if (sx == px && sy == py) begin
        shade_hit = 1'b1;
        shade_sel = SHADE_TAB[i].lvl;
      end
    end
  end

  // Layers in drawing order: eye body, corner blanking, shading, iris; a pixel off the display is dark.
  always_comb begin
    level = '0;
    if (px >= geom.left && px < geom.right && py >= geom.top && py < geom.bottom) begin
      level = levels[REG_LEVEL_FULL];
    end
    if (geom.h_gt2 && py == geom.top) begin
      if (geom.w_gt1 && px == geom.right - coord_t'(1)) level = '0;
      if (geom.w_gt2 && px == geom.left) level = '0;
    end
    if (geom.h_gt1 && py == geom.bottom - coord_t'(1)) begin
      if (geom.w_gt1 && px == geom.right - coord_t'(1)) level = '0;
      if (geom.w_gt2 && px == geom.left) level = '0;
    end
    if (geom.shade_on && shade_hit) begin
      level = levels[shade_sel];
    end
    if (px >= geom.ileft && px < geom.iright && py >= geom.itop && py < geom.ibot) begin
      level = '0;
    end
    if (!geom.on_display) begin
      level = '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/eye_sprite_pixel_renderer.sv -----
`default_nettype none

// Eye sprite pixel renderer: returns the brightness of one LED of a
// DISPLAY_WIDTH x DISPLAY_HEIGHT matrix showing an eye with shaded edges and a
// blanked iris. Each item carries the eye and iris shape plus the queried
// pixel; the block keeps no state between items. It accepts one item every
// clock cycle while in_ready is high, passing it through an input register,
// a geometry register and the output register; a stalled output backs up
// that three-deep pipeline before in_ready drops. The four brightness levels
// (full, dim, mid, bright at indexes 0 to 3) are to be written through the
// cfg_ port while no item is in flight; the block does not enforce this.
module eye_sprite_pixel_renderer
  import esr_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = 16,
  parameter int DISPLAY_HEIGHT = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [4:0]        in_eye_cols,
  input  wire logic [3:0]        in_eye_rows,
  input  wire logic signed [4:0] in_eye_offset_x,
  input  wire logic signed [4:0] in_eye_offset_y,
  input  wire logic [4:0]        in_iris_width,
  input  wire logic [3:0]        in_iris_height,
  input  wire logic signed [4:0] in_iris_offset_x,
  input  wire logic signed [4:0] in_iris_offset_y,
  input  wire logic [3:0]        in_pixel_x,
  input  wire logic [3:0]        in_pixel_y,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_pixel_level,
  input  wire logic              cfg_wr_en,
  input  wire logic [ADDR_W-1:0] cfg_addr,
  input  wire logic [7:0]        cfg_wdata
);

  level_bank_t levels_r;
  item_t       item_r, item_nxt;
  geom_t       geom_r, geom_nxt;
  level_t      level_r, level_nxt;
  logic        s1_v_r, s1_v_nxt;
  logic        s2_v_r, s2_v_nxt;
  logic        out_v_r, out_v_nxt;
  logic        out_free, s2_ready, s1_ready;

  // Brightness registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r[REG_LEVEL_FULL]   <= LEVEL_FULL_RST;
      levels_r[REG_LEVEL_DIM]    <= LEVEL_DIM_RST;
      levels_r[REG_LEVEL_MID]    <= LEVEL_MID_RST;
      levels_r[REG_LEVEL_BRIGHT] <= LEVEL_BRIGHT_RST;
    end else if (cfg_wr_en) begin
      levels_r[cfg_addr] <= cfg_wdata;
    end
  end

  // Pipeline flow control: a stage takes new data when it is empty or draining.
  assign out_free = !out_v_r || out_ready;
  assign s2_ready = !s2_v_r || out_free;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  assign s1_v_nxt  = s1_ready ? in_valid : s1_v_r;
  assign s2_v_nxt  = s2_ready ? s1_v_r : s2_v_r;
  assign out_v_nxt = out_free ? s2_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Input register.
  always_comb begin
    item_nxt               = item_r;
    if (in_valid && in_ready) begin
      item_nxt.eye_cols      = in_eye_cols;
      item_nxt.eye_rows      = in_eye_rows;
      item_nxt.eye_offset_x  = in_eye_offset_x;
      item_nxt.eye_offset_y  = in_eye_offset_y;
      item_nxt.iris_width    = in_iris_width;
      item_nxt.iris_height   = in_iris_height;
      item_nxt.iris_offset_x = in_iris_offset_x;
      item_nxt.iris_offset_y = in_iris_offset_y;
      item_nxt.pixel_x       = in_pixel_x;
      item_nxt.pixel_y       = in_pixel_y;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  // Rectangle placement and iris clamping.
  geom_t geom_c;

  esr_geom #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
  ) u_geom (
    .item(item_r),
    .geom(geom_c)
  );

  assign geom_nxt = (s1_v_r && s2_ready) ? geom_c : geom_r;

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  // Pixel level selection into the output register.
  level_t level_c;

  esr_shade u_shade (
    .geom  (geom_r),
    .levels(levels_r),
    .level (level_c)
  );

  assign level_nxt = (s2_v_r && out_free) ? level_c : level_r;

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
  end

  assign out_valid       = out_v_r;
  assign out_pixel_level = level_r;

  // An accepted item always lands in the input register.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_v_r)
    else $error("accepted item did not reach the input register");

  // An empty input register never refuses an item.
  a_empty_s1_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ready)
    else $error("input stage empty but not ready");

  // A pixel off the display is dark when it reaches the output.
  a_off_display_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_free && !geom_r.on_display) |=> (out_pixel_level == '0))
    else $error("pixel off the display is lit");

  // The clamped iris never reaches past the eye's bottom or right edge.
  a_iris_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (geom_r.ibot <= geom_r.bottom && geom_r.iright <= geom_r.right))
    else $error("iris extends past the eye edge");

endmodule

`default_nettype wire
